FILE: rtl/sme_pkg.sv
// shared types and codes for the stack machine executor
package sme_pkg;

	localparam int OPCODE_W = 3;
	localparam int ADDR_W   = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 7;

	localparam logic [OPCODE_W-1:0] OP_LOAD = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_MULT = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_END  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_POPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ENDED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADOP  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNDER  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVER   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_HALTED = 3'd6;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   data_in;
	} sme_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   value;
		logic [DEPTH_W-1:0]  stack_depth;
	} sme_rsp_t;

endpackage

FILE: rtl/sme_ram.sv
// generic simple dual-port ram with registered read
module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/stack_machine_executor.sv
// zero-address stack machine executor, top level
// a command passes through stage 1 and the response register before its result is valid
// throughput: one command per cycle unless rsp_ready holds the response; an operation touches
//   the stack ram at most once, the top of stack is held in a register and the entry below it is read from ram
// reset: stack count, halt flag and handshake state are cleared; data and stack
//   rams are not initialized
module stack_machine_executor #(
	parameter int DATA_DEPTH  = 256,
	parameter int STACK_DEPTH = 64,
	parameter int WORD_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  sme_pkg::sme_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sme_pkg::sme_rsp_t rsp
);

	import sme_pkg::*;

	localparam int DA_W = $clog2(DATA_DEPTH);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_NONE = 3'd0,
		ACT_PUSH = 3'd1,
		ACT_POP  = 3'd2,
		ACT_ADD  = 3'd3,
		ACT_MULT = 3'd4
	} act_t;

	// address folded into the data memory range by conditional subtraction
	function automatic logic [DA_W-1:0] data_index(input logic [ADDR_W-1:0] a);
		logic [ADDR_W:0] r;
		r = {1'b0, a};
		for (int k = ADDR_W - 1; k >= 0; k--) begin
			if ((longint'(DATA_DEPTH) << k) <= longint'(r)) begin
				r = r - (ADDR_W+1)'(longint'(DATA_DEPTH) << k);
			end
		end
		return DA_W'(r);
	endfunction

	// issue-side control
	logic [SP_W-1:0]  sp_q;
	logic             halted_q;
	logic             cmd_fire;
	logic [SP_W-1:0]  sp_n;
	logic             halt_n;
	logic [STATUS_W-1:0] status_n;
	act_t             act_n;
	logic             dm_we;
	logic             dm_re;
	logic             sm_re;
	logic [SA_W-1:0]  sm_raddr;
	logic             sm_wr_n;
	logic [DA_W-1:0]  dm_addr;

	// stage 1
	logic             valid_s1;
	act_t             act_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [SP_W-1:0]  sp_s1;
	logic             rd_s1;
	logic             wr_s1;
	logic [SA_W-1:0]  waddr_s1;
	logic             fwd_s1;
	logic             adv_s1;

	logic [WORD_WIDTH-1:0] tos_q;
	logic [WORD_WIDTH-1:0] fwd_data_q;
	logic [WORD_WIDTH-1:0] dm_rdata;
	logic [WORD_WIDTH-1:0] sm_rdata;
	logic [WORD_WIDTH-1:0] b_op;
	logic [WORD_WIDTH-1:0] prod;
	logic                  sm_we;

	logic     rsp_valid_q;
	sme_rsp_t rsp_q;

	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign dm_addr   = data_index(cmd.address);

	always_comb begin
		status_n = ST_OK;
		act_n    = ACT_NONE;
		sp_n     = sp_q;
		halt_n   = halted_q;
		dm_we    = 1'b0;
		dm_re    = 1'b0;
		sm_re    = 1'b0;
		sm_wr_n  = 1'b0;
		if (halted_q) begin
			status_n = ST_HALTED;
		end else begin
			unique case (cmd.opcode) inside
				OP_LOAD: begin
					dm_we = 1'b1;
				end
				OP_PUSH: begin
					if (sp_q >= SP_W'(STACK_DEPTH)) begin
						status_n = ST_OVER;
					end else begin
						act_n   = ACT_PUSH;
						dm_re   = 1'b1;
						sm_wr_n = (sp_q != '0);
						sp_n    = sp_q + SP_W'(1);
					end
				end
				OP_POP: begin
					if (sp_q == '0) begin
						status_n = ST_UNDER;
					end else begin
						act_n    = ACT_POP;
						status_n = ST_POPPED;
						sm_re    = (sp_q >= SP_W'(2));
						sp_n     = sp_q - SP_W'(1);
					end
				end
				OP_ADD, OP_MULT: begin
					if (sp_q < SP_W'(2)) begin
						status_n = ST_UNDER;
					end else begin
						act_n = (cmd.opcode == OP_ADD) ? ACT_ADD : ACT_MULT;
						sm_re = 1'b1;
						sp_n  = sp_q - SP_W'(1);
					end
				end
				OP_END: begin
					halt_n   = 1'b1;
					status_n = ST_ENDED;
				end
				default: begin
					status_n = ST_BADOP;
				end
			endcase
		end
	end

	// entry below the top of stack
	assign sm_raddr = SA_W'(sp_q - SP_W'(2));
	// old top of stack spills to ram when a push completes
	assign sm_we    = adv_s1 && wr_s1;

	sme_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(DATA_DEPTH)
	) u_data_ram (
		.clk  (clk),
		.we   (cmd_fire && dm_we),
		.waddr(dm_addr),
		.wdata(WORD_WIDTH'(cmd.data_in)),
		.re   (cmd_fire && dm_re),
		.raddr(dm_addr),
		.rdata(dm_rdata)
	);

	sme_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (sm_we),
		.waddr(waddr_s1),
		.wdata(tos_q),
		.re   (cmd_fire && sm_re),
		.raddr(sm_raddr),
		.rdata(sm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			halted_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd_fire) begin
				sp_q     <= sp_n;
				halted_q <= halt_n;
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			act_s1    <= act_n;
			status_s1 <= status_n;
			sp_s1     <= sp_n;
			rd_s1     <= sm_re;
			wr_s1     <= sm_wr_n;
			waddr_s1  <= SA_W'(sp_q - SP_W'(1));
			// read racing the spill of the previous push to the same entry
			fwd_s1    <= sm_we && sm_re && (waddr_s1 == sm_raddr);
		end
		if (sm_we) begin
			fwd_data_q <= tos_q;
		end
	end

	assign b_op = fwd_s1 ? fwd_data_q : sm_rdata;

	generate
		if (WORD_WIDTH <= 32) begin : g_mul_narrow
			assign prod = tos_q * b_op;
		end else begin : g_mul_wide
			localparam int HW = WORD_WIDTH - 32;
			logic [63:0]   p_ll;
			logic [HW-1:0] p_x;
			assign p_ll = tos_q[31:0] * b_op[31:0];
			assign p_x  = tos_q[WORD_WIDTH-1:32] * b_op[HW-1:0]
				+ tos_q[HW-1:0] * b_op[WORD_WIDTH-1:32];
			assign prod = WORD_WIDTH'(p_ll) + {p_x, 32'b0};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			unique case (act_s1)
				ACT_PUSH: tos_q <= dm_rdata;
				ACT_POP: begin
					if (rd_s1) begin
						tos_q <= b_op;
					end
				end
				ACT_ADD:  tos_q <= tos_q + b_op;
				ACT_MULT: tos_q <= prod;
				default: ;
			endcase
			rsp_q.status      <= status_s1;
			rsp_q.value       <= (act_s1 == ACT_POP) ? DATA_W'(tos_q) : '0;
			rsp_q.stack_depth <= DEPTH_W'(sp_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
